// ===== hw/rtl/path_normalizer_macros.svh =====
// Assertion macros for the path normalizer RTL.
`ifndef PATH_NORMALIZER_MACROS_SVH
`define PATH_NORMALIZER_MACROS_SVH

// Check that an expression holds at every clock edge out of reset.
`define PN_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("path_normalizer: invariant violated");

// Check that a condition in one cycle implies a result in the next cycle.
`define PN_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("path_normalizer: next-cycle check failed");

`endif

// ===== hw/rtl/pn_pkg.sv =====
// Shared types and constants for the path normalizer.
`timescale 1ns / 1ps

package pn_pkg;

  // Field widths fixed by the interface
  localparam int REQ_W     = 2;
  localparam int CHAR_W    = 8;
  localparam int IDX_W     = 12;
  localparam int STATUS_W  = 2;
  localparam int LEN_OUT_W = 12;
  localparam int CFG_W     = 13;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_CHAR = 2'd0;
  localparam logic [REQ_W-1:0] REQ_END  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ = 2'd2;
  localparam logic [REQ_W-1:0] REQ_NONE = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OOB     = 2'd2;

  // Dot classification of the name in progress
  localparam logic [1:0] DOTS_EMPTY = 2'd0;
  localparam logic [1:0] DOTS_ONE   = 2'd1;
  localparam logic [1:0] DOTS_TWO   = 2'd2;
  localparam logic [1:0] DOTS_NAME  = 2'd3;

  // Characters
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;

  // Buffer limit after reset
  localparam logic [CFG_W-1:0] CFG_RESET = 13'd4096;

  // Classified item passed from the front part to the back part
  typedef struct packed {
    logic [REQ_W-1:0]  kind;
    logic              is_sep;
    logic              is_dot;
    logic [CHAR_W-1:0] ch;
    logic [IDX_W-1:0]  idx;
  } cmd_t;

endpackage

// ===== hw/rtl/pn_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module pn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/pn_front.sv =====
// Front part: accepts input items, classifies them and queues them.
`timescale 1ns / 1ps

module pn_front import pn_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [CHAR_W-1:0] in_path_char,
  input  logic [IDX_W-1:0]  in_read_index,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output cmd_t              cmd
);

  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  cmd_t             cls;
  logic             push;
  logic             pop;

  // Classify the incoming item
  always_comb begin
    cls.kind   = in_req_type;
    cls.is_sep = (in_path_char == CH_SLASH) || (in_path_char == CH_BSLASH);
    cls.is_dot = (in_path_char == CH_DOT);
    cls.ch     = in_path_char;
    cls.idx    = in_read_index;
  end

  assign in_ready  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign cmd_valid = (count_r != '0);
  assign cmd       = q_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + PTR_W'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store the queued item
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

// ===== hw/rtl/pn_back.sv =====
// Back part: updates the normalized path, owns the stores and the result register.
`timescale 1ns / 1ps
`include "path_normalizer_macros.svh"

module pn_back import pn_pkg::*; #(
  parameter int PATH_BYTES = 4096,
  parameter int NAME_BYTES = 256,
  parameter int MAX_LEVELS = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 cmd_valid,
  output logic                 cmd_ready,
  input  cmd_t                 cmd,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [LEN_OUT_W-1:0] out_path_length,
  output logic [CHAR_W-1:0]    out_read_char
);

  localparam int LEN_W      = $clog2(PATH_BYTES);
  localparam int NAME_W     = $clog2(NAME_BYTES);
  localparam int DEPTH_W    = $clog2(MAX_LEVELS + 1);
  localparam int SADDR_W    = $clog2(MAX_LEVELS);
  localparam int WIDE_W     = $clog2(PATH_BYTES + NAME_BYTES) + 1;
  localparam int CMP_W      = (WIDE_W > CFG_W) ? WIDE_W : CFG_W;
  localparam int BANK_DEPTH = PATH_BYTES / 2;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam logic [CMP_W-1:0]   PATH_LIM   = CMP_W'(PATH_BYTES);
  localparam logic [NAME_W-1:0]  SPLIT_LEN  = NAME_W'(NAME_BYTES - 1);
  localparam logic [DEPTH_W-1:0] LEVELS_MAX = DEPTH_W'(MAX_LEVELS);

  // Clamp the buffer limit into the supported range
  function automatic logic [CMP_W-1:0] clamp_lim(input logic [CFG_W-1:0] v);
    logic [CMP_W-1:0] w;
    w = CMP_W'(v);
    if (w < CMP_W'(2)) begin
      w = CMP_W'(2);
    end else if (w > PATH_LIM) begin
      w = PATH_LIM;
    end
    return w;
  endfunction

  // Path state
  logic [LEN_W-1:0]    kept_r, kept_nxt;
  logic [DEPTH_W-1:0]  depth_r, depth_nxt;
  logic [NAME_W-1:0]   name_len_r, name_len_nxt;
  logic [1:0]          dots_r, dots_nxt;
  logic                seen_r, seen_nxt;
  logic [STATUS_W-1:0] err_r, err_nxt;
  logic [CMP_W-1:0]    eff_lim_r;

  // Execute-stage signals
  logic                exec;
  logic                sep_add;
  logic [CMP_W-1:0]    kept_w;
  logic [CMP_W-1:0]    pos_c;
  logic [CMP_W-1:0]    idx_w;
  logic [CMP_W-1:0]    newlen;
  logic [NAME_W-1:0]   name_inc;
  logic [1:0]          dots_c;
  logic                commit_en;
  logic [NAME_W-1:0]   commit_len;
  logic [1:0]          commit_dots;
  logic                push;
  logic                wr_slash;
  logic                wr_char;
  logic                rd_en;
  logic                rd_hit;
  logic [DEPTH_W-1:0]  stk_rd_ptr;
  logic [LEN_W-1:0]    stk_rdata;

  // Store banks: even and odd positions
  logic                bank_we    [2];
  logic [BANK_AW-1:0]  bank_waddr [2];
  logic [CHAR_W-1:0]   bank_wdata [2];
  logic [CHAR_W-1:0]   bank_rdata [2];
  logic [BANK_AW-1:0]  rd_addr;

  // Result stage and output register
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_adv;
  logic [STATUS_W-1:0]  s1_status_r;
  logic [LEN_OUT_W-1:0] s1_len_r;
  logic                 s1_hit_r;
  logic                 s1_root_r;
  logic                 s1_bank_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [STATUS_W-1:0]  out_status_r;
  logic [LEN_OUT_W-1:0] out_len_r;
  logic [CHAR_W-1:0]    out_char_r;
  logic [CHAR_W-1:0]    s1_char;

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_ready);
  assign cmd_ready = !s1_valid_r || s1_adv;
  assign exec      = cmd_valid && cmd_ready;

  // Position arithmetic for the current item
  assign sep_add  = (kept_r > LEN_W'(1));
  assign kept_w   = CMP_W'(kept_r);
  assign pos_c    = kept_w + CMP_W'(sep_add) + CMP_W'(name_len_r);
  assign idx_w    = CMP_W'(cmd.idx);
  assign name_inc = name_len_r + NAME_W'(1);
  assign rd_hit   = (idx_w < kept_w);
  assign rd_addr  = idx_w[BANK_AW:1];

  // Classify the name after this character
  always_comb begin
    if (name_len_r == '0) begin
      dots_c = cmd.is_dot ? DOTS_ONE : DOTS_NAME;
    end else if ((dots_r == DOTS_ONE) && cmd.is_dot) begin
      dots_c = DOTS_TWO;
    end else begin
      dots_c = DOTS_NAME;
    end
  end

  // Update the path state for one item
  always_comb begin
    kept_nxt     = kept_r;
    depth_nxt    = depth_r;
    name_len_nxt = name_len_r;
    dots_nxt     = dots_r;
    seen_nxt     = seen_r;
    err_nxt      = err_r;
    commit_en    = 1'b0;
    commit_len   = name_len_r;
    commit_dots  = dots_r;
    wr_slash     = 1'b0;
    wr_char      = 1'b0;
    rd_en        = 1'b0;
    push         = 1'b0;
    if (exec) begin
      unique case (cmd.kind)
        REQ_CHAR: begin
          if (!seen_r) begin
            // First character opens a new path
            seen_nxt     = 1'b1;
            depth_nxt    = '0;
            name_len_nxt = '0;
            dots_nxt     = DOTS_EMPTY;
            if (cmd.is_sep) begin
              err_nxt  = ST_OK;
              kept_nxt = LEN_W'(1);
            end else begin
              err_nxt = ST_INVALID;
            end
          end else if (err_r == ST_OK) begin
            if (cmd.is_sep) begin
              commit_en = (name_len_r != '0);
            end else begin
              wr_slash = (name_len_r == '0) && sep_add;
              wr_char  = (pos_c < PATH_LIM);
              if (name_inc >= SPLIT_LEN) begin
                commit_en   = 1'b1;
                commit_len  = name_inc;
                commit_dots = dots_c;
              end else begin
                name_len_nxt = name_inc;
                dots_nxt     = dots_c;
              end
            end
          end
        end
        REQ_END: begin
          if (!seen_r) begin
            err_nxt = ST_INVALID;
          end else if ((err_r == ST_OK) && (name_len_r != '0)) begin
            commit_en = 1'b1;
          end
          name_len_nxt = '0;
          dots_nxt     = DOTS_EMPTY;
          seen_nxt     = 1'b0;
        end
        REQ_READ: begin
          rd_en = 1'b1;
        end
        REQ_NONE: begin
        end
      endcase
    end

    // Commit a finished component
    newlen = kept_w + CMP_W'(sep_add) + CMP_W'(commit_len);
    if (commit_en) begin
      name_len_nxt = '0;
      dots_nxt     = DOTS_EMPTY;
      unique case (commit_dots)
        DOTS_ONE: begin
        end
        DOTS_TWO: begin
          if (depth_r != '0) begin
            depth_nxt = depth_r - DEPTH_W'(1);
            kept_nxt  = stk_rdata;
          end
        end
        default: begin
          if ((newlen >= eff_lim_r) || (depth_r >= LEVELS_MAX)) begin
            err_nxt = ST_OOB;
          end else begin
            push      = 1'b1;
            depth_nxt = depth_r + DEPTH_W'(1);
            kept_nxt  = newlen[LEN_W-1:0];
          end
        end
      endcase
    end
  end

  // Slash position stack; the top entry is read every cycle
  assign stk_rd_ptr = depth_r - DEPTH_W'(1);

  pn_ram #(
    .WIDTH (LEN_W),
    .DEPTH (MAX_LEVELS)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (depth_r[SADDR_W-1:0]),
    .wdata (kept_r),
    .re    (1'b1),
    .raddr (stk_rd_ptr[SADDR_W-1:0]),
    .rdata (stk_rdata)
  );

  // Output store split into even and odd banks so slash and character land together
  for (genvar b = 0; b < 2; b++) begin : g_bank
    always_comb begin
      bank_we[b]    = 1'b0;
      bank_waddr[b] = kept_r[BANK_AW:1];
      bank_wdata[b] = CH_SLASH;
      if (wr_slash && (kept_r[0] == 1'(b))) begin
        bank_we[b] = 1'b1;
      end else if (wr_char && (pos_c[0] == 1'(b))) begin
        bank_we[b]    = 1'b1;
        bank_waddr[b] = pos_c[BANK_AW:1];
        bank_wdata[b] = cmd.ch;
      end
    end

    pn_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (BANK_DEPTH)
    ) u_store (
      .clk   (clk),
      .we    (bank_we[b]),
      .waddr (bank_waddr[b]),
      .wdata (bank_wdata[b]),
      .re    (rd_en),
      .raddr (rd_addr),
      .rdata (bank_rdata[b])
    );
  end

  // Hold path state and the effective limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kept_r     <= LEN_W'(1);
      depth_r    <= '0;
      name_len_r <= '0;
      dots_r     <= DOTS_EMPTY;
      seen_r     <= 1'b0;
      err_r      <= ST_OK;
      eff_lim_r  <= clamp_lim(CFG_RESET);
    end else begin
      kept_r     <= kept_nxt;
      depth_r    <= depth_nxt;
      name_len_r <= name_len_nxt;
      dots_r     <= dots_nxt;
      seen_r     <= seen_nxt;
      err_r      <= err_nxt;
      if (cfg_wr_en) begin
        eff_lim_r <= clamp_lim(cfg_wr_data);
      end
    end
  end

  // Result stage: wait for the store read data
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (exec) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (exec) begin
      s1_status_r <= err_nxt;
      s1_len_r    <= LEN_OUT_W'(kept_nxt);
      s1_hit_r    <= (cmd.kind == REQ_READ) && rd_hit;
      s1_root_r   <= (cmd.idx == '0);
      s1_bank_r   <= idx_w[0];
    end
  end

  // Output register
  always_comb begin
    if (!s1_hit_r) begin
      s1_char = '0;
    end else if (s1_root_r) begin
      s1_char = CH_SLASH;
    end else begin
      s1_char = bank_rdata[s1_bank_r];
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= s1_status_r;
      out_len_r    <= s1_len_r;
      out_char_r   <= s1_char;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_path_length = out_len_r;
  assign out_read_char   = out_char_r;

  // Checks
  `PN_ASSERT_ALWAYS(a_depth_bound, depth_r <= LEVELS_MAX)
  `PN_ASSERT_ALWAYS(a_kept_nonzero, kept_r != '0)
  `PN_ASSERT_NEXT(a_err_sticky, seen_r && (err_r != ST_OK), err_r == $past(err_r))
  `PN_ASSERT_NEXT(a_s1_hold, s1_valid_r && out_valid_r && !out_ready, s1_valid_r && $stable(s1_len_r) && $stable(s1_status_r))

endmodule

// ===== hw/rtl/path_normalizer.sv =====
// Top level of the path normalizer: front classifier, item queue and back executor.
// Each item passes the item queue, the result stage and the output register before its result is valid.
// Throughput: one item per cycle while out_ready is high, set by the path state update
// and the one write port of each even/odd output store bank.
// Reset (rst_n low, synchronous) empties the queue and result stages, sets the
// path to the root and buffer_limit to 4096; stores are not cleared.
`timescale 1ns / 1ps

module path_normalizer import pn_pkg::*; #(
  parameter int PATH_BYTES = 4096,
  parameter int NAME_BYTES = 256,
  parameter int MAX_LEVELS = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [REQ_W-1:0]     in_req_type,
  input  logic [CHAR_W-1:0]    in_path_char,
  input  logic [IDX_W-1:0]     in_read_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STATUS_W-1:0]  out_status,
  output logic [LEN_OUT_W-1:0] out_path_length,
  output logic [CHAR_W-1:0]    out_read_char
);

  logic cmd_valid;
  logic cmd_ready;
  cmd_t cmd;

  // Accept and classify items
  pn_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_req_type   (in_req_type),
    .in_path_char  (in_path_char),
    .in_read_index (in_read_index),
    .cmd_valid     (cmd_valid),
    .cmd_ready     (cmd_ready),
    .cmd           (cmd)
  );

  // Execute items against the path state
  pn_back #(
    .PATH_BYTES (PATH_BYTES),
    .NAME_BYTES (NAME_BYTES),
    .MAX_LEVELS (MAX_LEVELS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .cmd_valid       (cmd_valid),
    .cmd_ready       (cmd_ready),
    .cmd             (cmd),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_path_length (out_path_length),
    .out_read_char   (out_read_char)
  );

endmodule
